@@ rtl/sfei_pkg.sv @@
// shared constants, types and helpers for the sorted free extent insert block
`timescale 1ns / 1ps

package sfei_pkg;

   localparam int Entries      = 16;
   localparam int CountBits    = $clog2(Entries + 1);
   localparam int AddrBits     = 32;
   localparam int FieldBits    = 32;
   localparam int SizeBits     = 32;
   localparam int KindBits     = 2;
   localparam int CountOutBits = 5;
   localparam int ReqDataBits  = 64;
   localparam int RspDataBits  = 72;
   localparam int RspUserBits  = 3;

   localparam logic [KindBits-1:0] KindNone  = 2'd0;
   localparam logic [KindBits-1:0] KindLower = 2'd1;
   localparam logic [KindBits-1:0] KindUpper = 2'd2;
   localparam logic [KindBits-1:0] KindBoth  = 2'd3;

   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [SizeBits-1:0]  size_type;
   typedef logic [FieldBits-1:0] field_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [Entries-1:0]   mask_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic pick;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   function automatic addr_type to_addr(input field_type v);
      logic [FieldBits+AddrBits-1:0] wide;
      wide = {{AddrBits{1'b0}}, v};
      return wide[AddrBits-1:0];
   endfunction

   function automatic field_type from_addr(input addr_type a);
      logic [FieldBits+AddrBits-1:0] wide;
      wide = {{FieldBits{1'b0}}, a};
      return wide[FieldBits-1:0];
   endfunction

   // saturating sum of three sizes
   function automatic size_type sat_add3(input size_type a, input size_type b,
                                         input size_type c);
      logic [SizeBits+1:0] s;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c};
      return (|s[SizeBits+1:SizeBits]) ? {SizeBits{1'b1}} : s[SizeBits-1:0];
   endfunction

endpackage

@@ rtl/sorted_free_extent_insert.sv @@
// top level: address-ordered free extent table with coalescing on insert
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: block_address, block_size
//  rsp     | out       | rsp_tvalid/tready    | tdata: extent_start, extent_size,
//          |           |                      |   extent_count; tuser: merge_kind, overflow
//
// an item goes through four steps, its result registered at the last: accept,
// compare against every cell, pick the neighbors, then merge and update the row
// the merge step waits while the previous result is still held on rsp
// a new item is accepted while a result waits to be taken
// reset empties the table
`timescale 1ns / 1ps

module sorted_free_extent_insert (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // block_address [31:0], block_size [63:32]
   input  logic [sfei_pkg::ReqDataBits-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // extent_start [31:0], extent_size [63:32], extent_count [68:64], zero fill
   output logic [sfei_pkg::RspDataBits-1:0] rsp_tdata,
   // merge_kind [1:0], overflow [2]
   output logic [sfei_pkg::RspUserBits-1:0] rsp_tuser
);

   sfei_pkg::cmd_type    cmd;
   sfei_pkg::status_type status;

   sfei_pkg::field_type               res_start;
   sfei_pkg::size_type                res_size;
   logic [sfei_pkg::KindBits-1:0]     res_kind;
   logic                              res_ovf;
   logic [sfei_pkg::CountOutBits-1:0] res_count;

   sfei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sfei_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_address   (req_tdata[31:0]),
      .in_size      (req_tdata[63:32]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_start    (res_start),
      .rsp_size     (res_size),
      .rsp_kind     (res_kind),
      .rsp_overflow (res_ovf),
      .rsp_count    (res_count)
   );

   assign rsp_tdata = {3'b000, res_count, res_size, res_start};
   assign rsp_tuser = {res_ovf, res_kind};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:64] <= sfei_pkg::CountOutBits'(sfei_pkg::Entries))
      else $error("extent count above table size");

   a_ovf_no_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == sfei_pkg::KindNone)
      else $error("dropped item reports a merge");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2]
      |-> rsp_tdata[68:64] == sfei_pkg::CountOutBits'(sfei_pkg::Entries))
      else $error("dropped item while table not full");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

endmodule

@@ rtl/sfei_dpath.sv @@
// datapath: extent cells, neighbor search, merge arithmetic and result register
`timescale 1ns / 1ps

module sfei_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  sfei_pkg::cmd_type                cmd,
   output sfei_pkg::status_type             status,
   input  sfei_pkg::field_type              in_address,
   input  sfei_pkg::field_type              in_size,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sfei_pkg::field_type              rsp_start,
   output sfei_pkg::size_type               rsp_size,
   output logic [sfei_pkg::KindBits-1:0]    rsp_kind,
   output logic                             rsp_overflow,
   output logic [sfei_pkg::CountOutBits-1:0] rsp_count
);

   sfei_pkg::addr_type  ext_start_ff [sfei_pkg::Entries];
   sfei_pkg::size_type  ext_size_ff  [sfei_pkg::Entries];
   sfei_pkg::addr_type  above_start  [sfei_pkg::Entries];
   sfei_pkg::size_type  above_size   [sfei_pkg::Entries];
   sfei_pkg::addr_type  below_start  [sfei_pkg::Entries];
   sfei_pkg::size_type  below_size   [sfei_pkg::Entries];
   sfei_pkg::count_type count_ff;

   sfei_pkg::addr_type blk_addr_ff;
   sfei_pkg::size_type blk_size_ff;

   sfei_pkg::mask_type le_ff, le_in;
   sfei_pkg::mask_type eq_lo_ff, eq_lo_in;
   sfei_pkg::mask_type eq_hi_ff, eq_hi_in;
   sfei_pkg::addr_type up_end;

   sfei_pkg::mask_type valid_mask, low_sel, ins_sel;
   sfei_pkg::mask_type low_sel_ff, ins_ff;
   logic               lo_ff, hi_ff, lo_in, hi_in;
   sfei_pkg::addr_type lo_start_ff, lo_start_in;
   sfei_pkg::size_type lo_size_ff, lo_size_in, hi_size_ff, hi_size_in;

   sfei_pkg::size_type merged;
   logic               full;
   sfei_pkg::count_type count_in;
   logic [sfei_pkg::KindBits-1:0] kind;

   logic                             rsp_valid_ff;
   sfei_pkg::field_type              res_start_ff;
   sfei_pkg::size_type               res_size_ff;
   logic [sfei_pkg::KindBits-1:0]    res_kind_ff;
   logic                             res_ovf_ff;
   logic [sfei_pkg::CountOutBits-1:0] res_count_ff;

   // neighbor taps for shifting the row
   for (genvar i = 0; i < sfei_pkg::Entries; i++) begin : g_tap
      if (i + 1 < sfei_pkg::Entries) begin : g_above
         assign above_start[i] = ext_start_ff[i+1];
         assign above_size[i]  = ext_size_ff[i+1];
      end else begin : g_top
         assign above_start[i] = ext_start_ff[i];
         assign above_size[i]  = ext_size_ff[i];
      end
      if (i > 0) begin : g_below
         assign below_start[i] = ext_start_ff[i-1];
         assign below_size[i]  = ext_size_ff[i-1];
      end else begin : g_bottom
         assign below_start[i] = ext_start_ff[i];
         assign below_size[i]  = ext_size_ff[i];
      end
   end

   // scan: per-cell compares against the block
   assign up_end = blk_addr_ff + sfei_pkg::to_addr(blk_size_ff);

   always_comb begin
      for (int i = 0; i < sfei_pkg::Entries; i++) begin
         valid_mask[i] = sfei_pkg::CountBits'(i) < count_ff;
         le_in[i]      = valid_mask[i] && (ext_start_ff[i] <= blk_addr_ff);
         eq_lo_in[i]   = (ext_start_ff[i] + sfei_pkg::to_addr(ext_size_ff[i])) == blk_addr_ff;
         eq_hi_in[i]   = ext_start_ff[i] == up_end;
      end
   end

   // pick: lower and upper neighbors as one-hot selects
   assign low_sel = le_ff & ~(le_ff >> 1);
   assign ins_sel = ~le_ff & ((le_ff << 1) | sfei_pkg::mask_type'(1));

   always_comb begin
      lo_in       = |(low_sel & eq_lo_ff);
      hi_in       = |(ins_sel & valid_mask & eq_hi_ff);
      lo_start_in = '0;
      lo_size_in  = '0;
      hi_size_in  = '0;
      for (int i = 0; i < sfei_pkg::Entries; i++) begin
         lo_start_in = lo_start_in | ({sfei_pkg::AddrBits{low_sel[i]}} & ext_start_ff[i]);
         lo_size_in  = lo_size_in  | ({sfei_pkg::SizeBits{low_sel[i]}} & ext_size_ff[i]);
         hi_size_in  = hi_size_in  | ({sfei_pkg::SizeBits{ins_sel[i]}} & ext_size_ff[i]);
      end
   end

   // commit: merged size, kind and new count
   assign merged = sfei_pkg::sat_add3(lo_ff ? lo_size_ff : '0, blk_size_ff,
                                      hi_ff ? hi_size_ff : '0);
   assign full   = count_ff == sfei_pkg::CountBits'(sfei_pkg::Entries);

   always_comb begin
      kind     = sfei_pkg::KindNone;
      count_in = count_ff;
      priority if (lo_ff && hi_ff) begin
         kind     = sfei_pkg::KindBoth;
         count_in = count_ff - 1'b1;
      end else if (lo_ff) begin
         kind = sfei_pkg::KindLower;
      end else if (hi_ff) begin
         kind = sfei_pkg::KindUpper;
      end else if (!full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_addr_ff <= sfei_pkg::to_addr(in_address);
         blk_size_ff <= in_size;
      end
      if (cmd.scan) begin
         le_ff    <= le_in;
         eq_lo_ff <= eq_lo_in;
         eq_hi_ff <= eq_hi_in;
      end
      if (cmd.pick) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         low_sel_ff  <= low_sel;
         ins_ff      <= ins_sel;
         lo_start_ff <= lo_start_in;
         lo_size_ff  <= lo_size_in;
         hi_size_ff  <= hi_size_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < sfei_pkg::Entries; i++) begin
            priority if (lo_ff && hi_ff) begin
               if (low_sel_ff[i]) begin
                  ext_size_ff[i] <= merged;
               end else if (!le_ff[i]) begin
                  ext_start_ff[i] <= above_start[i];
                  ext_size_ff[i]  <= above_size[i];
               end
            end else if (lo_ff) begin
               if (low_sel_ff[i]) begin
                  ext_size_ff[i] <= merged;
               end
            end else if (hi_ff || !full) begin
               if (ins_ff[i]) begin
                  ext_start_ff[i] <= blk_addr_ff;
                  ext_size_ff[i]  <= merged;
               end else if (!hi_ff && !le_ff[i]) begin
                  ext_start_ff[i] <= below_start[i];
                  ext_size_ff[i]  <= below_size[i];
               end
            end
         end
         res_start_ff <= sfei_pkg::from_addr(lo_ff ? lo_start_ff : blk_addr_ff);
         res_size_ff  <= merged;
         res_kind_ff  <= kind;
         res_ovf_ff   <= !lo_ff && !hi_ff && full;
         res_count_ff <= sfei_pkg::CountOutBits'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_start    = res_start_ff;
   assign rsp_size     = res_size_ff;
   assign rsp_kind     = res_kind_ff;
   assign rsp_overflow = res_ovf_ff;
   assign rsp_count    = res_count_ff;

endmodule

@@ rtl/sfei_ctrl.sv @@
// controller: sequences load, scan, pick and commit for one item at a time
`timescale 1ns / 1ps

module sfei_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sfei_pkg::status_type status,
   output sfei_pkg::cmd_type    cmd
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StScan   = 2'd1;
   localparam logic [1:0] StPick   = 2'd2;
   localparam logic [1:0] StCommit = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.pick   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         StIdle: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = StScan;
            end
         end
         StScan: begin
            cmd.scan = 1'b1;
            state_in = StPick;
         end
         StPick: begin
            cmd.pick = 1'b1;
            state_in = StCommit;
         end
         StCommit: begin
            // wait for the result register to drain
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == StIdle;

endmodule
